// ===== design/fds_pkg.sv =====
`default_nettype none
package fds_pkg;

  // field widths
  localparam int unsigned NameHeadW = 64;
  localparam int unsigned NameExtW  = 24;
  localparam int unsigned AttrW     = 8;
  localparam int unsigned ClusW     = 32;
  localparam int unsigned LenW      = 32;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CharW     = 8;
  localparam int unsigned MaxChars  = 12;
  localparam int unsigned CntW      = $clog2(MaxChars + 1);

  // stream widths
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 3;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [0:0]  RegAnyMode = 1'b0;

  // entry kinds
  localparam logic [KindW-1:0] KindEnd   = 2'd0;
  localparam logic [KindW-1:0] KindBare  = 2'd1;
  localparam logic [KindW-1:0] KindNamed = 2'd2;

  // byte codes
  localparam logic [7:0] ByteDeleted = 8'hE5;
  localparam logic [7:0] ByteSpace   = 8'h20;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpZ     = 8'h5A;
  localparam logic [7:0] LowerOffset = 8'd32;
  localparam logic [7:0] AttrVolume  = 8'h08;
  localparam logic [7:0] AttrLfnMask = 8'h3F;
  localparam logic [7:0] AttrLfn     = 8'h0F;
  localparam logic [7:0] AttrVolSys  = 8'h0C;

  // one directory entry as taken from the input beat
  typedef struct packed {
    logic [NameHeadW-1:0] name_head;
    logic [NameExtW-1:0]  name_ext;
    logic [AttrW-1:0]     attr_byte;
    logic [ClusW-1:0]     start_cluster;
    logic [LenW-1:0]      length;
  } entry_t;

  // classified entry handed to the emitter
  typedef struct packed {
    logic                            skip;
    logic [KindW-1:0]                kind;
    logic                            has_chars;
    logic [CntW-1:0]                 cnt;
    logic [MaxChars-1:0][CharW-1:0]  chars;
    logic [AttrW-1:0]                attr;
    logic [ClusW-1:0]                clus;
    logic [LenW-1:0]                 len;
  } fmt_t;

  // fold A-Z to lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      r = c + LowerOffset;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/fat_dir_entry_scanner.sv =====
// the entry is registered in the input register, then loaded into the emitter registers
// throughput: at most one result beat per cycle, held while out_tready is low; a name
// of n characters gives n beats (1 to 12), a skipped entry none, any other entry one
// the input register takes the next entry while the emitter is still busy
// reset: synchronous, active low; clears both valid flags and any_mode
`default_nettype none
module fat_dir_entry_scanner (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration port
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire  [fds_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  wire  [fds_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [fds_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready,
  // entry input
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // name_head[63:0], name_ext[87:64], attr_byte[95:88],
  // start_cluster_in[127:96], length_in[159:128]
  input  wire  [fds_pkg::InDataW-1:0]    in_tdata,
  // result output
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // name_char[7:0], attr_out[15:8], start_cluster_out[47:16], length_out[79:48]
  output logic [fds_pkg::OutDataW-1:0]   out_tdata,
  // entry_kind[1:0], char_valid[2]
  output logic [fds_pkg::OutUserW-1:0]   out_tuser,
  output logic                           out_tlast
);
  import fds_pkg::*;

  logic   any_mode_r;
  logic   in_valid_r;
  entry_t entry_r;
  fmt_t   fmt;
  logic   fmt_take;
  logic   reg_sel;

  // configuration register
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CfgAddrW-1:2] == RegAnyMode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      any_mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = reg_sel ? {{(CfgDataW-1){1'b0}}, any_mode_r} : '0;

  // input register
  assign in_tready = !in_valid_r || fmt_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fmt_take) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      entry_r.name_head     <= in_tdata[63:0];
      entry_r.name_ext      <= in_tdata[87:64];
      entry_r.attr_byte     <= in_tdata[95:88];
      entry_r.start_cluster <= in_tdata[127:96];
      entry_r.length        <= in_tdata[159:128];
    end
  end

  // classify and format
  fds_fmt u_fmt (
    .entry    (entry_r),
    .any_mode (any_mode_r),
    .fmt      (fmt)
  );

  // result emitter
  fds_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt_valid  (in_valid_r),
    .fmt        (fmt),
    .fmt_take   (fmt_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== design/fds_fmt.sv =====
`default_nettype none
module fds_fmt (
  input  wire  fds_pkg::entry_t entry,
  input  wire                   any_mode,
  output fds_pkg::fmt_t         fmt
);
  import fds_pkg::*;

  logic [10:0][7:0]               nb;
  logic                           is_end;
  logic                           is_special;
  logic                           is_volsys;
  logic                           ext_kept;
  logic [CntW-1:0]                n;
  logic [MaxChars-1:0][CharW-1:0] text;

  assign nb = {entry.name_ext, entry.name_head};

  // classification, in rule order
  assign is_end     = (nb[0] == 8'h00);
  assign is_special = (entry.attr_byte == AttrVolume) || (nb[0] == ByteDeleted) ||
                      ((entry.attr_byte & AttrLfnMask) == AttrLfn);
  assign is_volsys  = ((entry.attr_byte & AttrLfnMask) == AttrVolSys);

  // the dot survives only if some extension byte is kept after it
  assign ext_kept = (nb[8] != ByteSpace) || (nb[9] != ByteSpace) || (nb[10] != ByteSpace);

  // pack kept characters to the front
  always_comb begin
    n    = '0;
    text = '0;
    for (int i = 0; i < 8; i++) begin
      if (nb[i] != ByteSpace) begin
        text[n] = to_lower(nb[i]);
        n       = n + 1'b1;
      end
    end
    if (ext_kept) begin
      text[n] = CharDot;
      n       = n + 1'b1;
      for (int i = 8; i < 11; i++) begin
        if (nb[i] != ByteSpace) begin
          text[n] = to_lower(nb[i]);
          n       = n + 1'b1;
        end
      end
      // a dot as the last kept extension character is dropped too
      if (text[n - 1'b1] == CharDot) begin
        n       = n - 1'b1;
        text[n] = '0;
      end
    end
  end

  // result descriptor
  always_comb begin
    fmt.skip      = 1'b0;
    fmt.kind      = KindNamed;
    fmt.has_chars = 1'b0;
    fmt.cnt       = CntW'(1);
    fmt.chars     = text;
    fmt.attr      = entry.attr_byte;
    fmt.clus      = entry.start_cluster;
    fmt.len       = entry.length;
    priority if (is_end) begin
      fmt.kind = KindEnd;
      fmt.attr = '0;
      fmt.clus = '0;
      fmt.len  = '0;
    end else if (is_special) begin
      fmt.kind = KindBare;
      fmt.skip = !any_mode;
    end else if (is_volsys) begin
      fmt.skip = 1'b1;
    end else begin
      if (n != '0) begin
        fmt.has_chars = 1'b1;
        fmt.cnt       = n;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/fds_emit.sv =====
`default_nettype none
module fds_emit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            fmt_valid,
  input  wire  fds_pkg::fmt_t            fmt,
  output logic                           fmt_take,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [fds_pkg::OutDataW-1:0]   out_tdata,
  output logic [fds_pkg::OutUserW-1:0]   out_tuser,
  output logic                           out_tlast
);
  import fds_pkg::*;

  logic                           busy_r;
  logic [CntW-1:0]                idx_r;
  logic [CntW-1:0]                cnt_r;
  logic [KindW-1:0]               kind_r;
  logic                           has_chars_r;
  logic [MaxChars-1:0][CharW-1:0] chars_r;
  logic [AttrW-1:0]               attr_r;
  logic [ClusW-1:0]               clus_r;
  logic [LenW-1:0]                len_r;
  logic                           last;
  logic                           can_load;
  logic [CharW-1:0]               ch;

  assign last     = (idx_r == cnt_r - 1'b1);
  assign can_load = !busy_r || (out_tready && last);
  assign fmt_take = fmt_valid && can_load;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (fmt_take) begin
      busy_r <= !fmt.skip;
      idx_r  <= '0;
    end else if (busy_r && out_tready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (fmt_take) begin
      cnt_r       <= fmt.cnt;
      kind_r      <= fmt.kind;
      has_chars_r <= fmt.has_chars;
      chars_r     <= fmt.chars;
      attr_r      <= fmt.attr;
      clus_r      <= fmt.clus;
      len_r       <= fmt.len;
    end
  end

  assign ch = has_chars_r ? chars_r[idx_r] : '0;

  // output beat
  assign out_tvalid = busy_r;
  assign out_tlast  = last;
  assign out_tdata  = {len_r, clus_r, attr_r, ch};
  assign out_tuser  = {has_chars_r, kind_r};

endmodule
`default_nettype wire
